### src/ple_pkg.sv
`default_nettype none

package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    localparam logic [2:0] FN_INSERT  = 3'd0;
    localparam logic [2:0] FN_REMOVE  = 3'd1;
    localparam logic [2:0] FN_DUMP    = 3'd2;
    localparam logic [2:0] FN_MOVE    = 3'd3;
    localparam logic [2:0] FN_REVERSE = 3'd4;
    localparam logic [2:0] FN_ROTL    = 3'd5;
    localparam logic [2:0] FN_ROTR    = 3'd6;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SU_RD, S_SU_WR, S_SD_RD, S_SD_WR, S_MV_RD, S_MV_HOLD,
        S_RV_RD0, S_RV_RD1, S_RV_W0, S_RV_W1, S_DP_RD, S_DP_EMIT, S_DONE, S_REPLY
    } t_state;

    typedef enum logic [3:0] {
        SET_NONE, SET_INS, SET_REM, SET_MVDN, SET_MVUP, SET_REV_ALL, SET_ROT_A,
        SET_ROT_B, SET_DUMP
    } t_setup;

    typedef enum logic [2:0] {RD_LO, RD_HI, RD_LO1, RD_HI1, RD_POS} t_rd;

    typedef enum logic [2:0] {
        WR_NONE, WR_LO_RD, WR_HI_RD, WR_HI_HOLD, WR_TGT_HOLD, WR_LO_VAL
    } t_wr;

    typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} t_cnt;

    typedef enum logic [1:0] {OUT_NONE, OUT_STATUS, OUT_DUMP} t_out;

    typedef struct packed {
        logic    load_op;
        t_setup  setup;
        logic    lo_inc;
        logic    hi_dec;
        t_rd     rd;
        t_wr     wr;
        logic    hold_ld;
        t_cnt    cnt;
        t_out    out;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       lo_lt_hi;
        logic       ins_full;
        logic       rem_bad;
        logic       mov_bad;
        logic       mov_eq;
        logic       mov_up;
        logic       rot_zero;
        logic       rot_bad;
        logic       n_lt2;
        logic       empty;
        logic       dump_last;
        logic       out_free;
    } t_flags;

endpackage

`default_nettype wire

### src/ple_in_if.sv
`default_nettype none

interface ple_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [6:0]         position;
    logic [5:0]         target_position;

    modport source (output valid, func, value, position, target_position, input ready);
    modport sink (input valid, func, value, position, target_position, output ready);
endinterface

`default_nettype wire

### src/ple_out_if.sv
`default_nettype none

interface ple_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_res;
    logic               last;
    logic [1:0]         status;

    modport source (output valid, value_res, last, status, input ready);
    modport sink (input valid, value_res, last, status, output ready);
endinterface

`default_nettype wire

### src/positional_list_engine.sv
// Positional list engine: keeps an ordered list of up to CAPACITY signed 32-bit words in a
// single-port-read, single-port-write memory and runs one operation per input transfer
// (insert, remove, dump, move, reverse, rotate left, rotate right). Every operation yields one
// status transfer, except a non-empty dump, which yields one transfer per word with last set on
// the final one. The memory sets the pace: each shifted word is read and then written back,
// for insert, remove and move alike, and move first reads and holds the moved word; reverse
// swaps words pairwise from both ends, rotation runs as three reversals, dump reads each word
// before it is emitted, and a rejected or trivial operation goes straight to its status reply.
// A new operation is taken only once the previous one has finished, though a finished result
// may still be waiting in the output register.
`default_nettype none

module positional_list_engine (
    input  wire  i_clk,
    input  wire  i_rst_n,
    ple_in_if.sink    i_in,
    ple_out_if.source o_out
);
    import ple_pkg::*;

    t_cmd   cmd;
    t_flags flags;

    // The controller sequences each operation; the datapath owns the memory and counters.
    ple_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_flags    (flags),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    ple_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_func            (i_in.func),
        .i_value           (i_in.value),
        .i_position        (i_in.position),
        .i_target_position (i_in.target_position),
        .i_out_ready       (o_out.ready),
        .o_flags           (flags),
        .o_out_valid       (o_out.valid),
        .o_value_res       (o_out.value_res),
        .o_last            (o_out.last),
        .o_status          (o_out.status)
    );

endmodule

`default_nettype wire

### src/ple_datapath.sv
`default_nettype none

module ple_datapath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ple_pkg::t_cmd       i_cmd,
    input  wire [2:0]           i_func,
    input  wire signed [31:0]   i_value,
    input  wire [6:0]           i_position,
    input  wire [5:0]           i_target_position,
    input  wire                 i_out_ready,
    output ple_pkg::t_flags     o_flags,
    output logic                o_out_valid,
    output logic signed [31:0]  o_value_res,
    output logic                o_last,
    output logic [1:0]          o_status
);
    import ple_pkg::*;

    logic [31:0]        mem [CAPACITY];
    logic [31:0]        r_rdata;
    logic [31:0]        r_hold;
    logic [2:0]         r_func;
    logic signed [31:0] r_val;
    logic [6:0]         r_pos;
    logic [5:0]         r_tgt;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    logic               r_out_last;
    logic [1:0]         r_out_status;

    logic [CMP_W-1:0]   pos_w, tgt_w, n_w;
    logic [CNT_W-1:0]   pos_n, tgt_n, rot_x, raddr_c, waddr_c;
    logic [31:0]        wdata;
    logic               we;
    logic               out_free;

    assign pos_w = CMP_W'(r_pos);
    assign tgt_w = CMP_W'(r_tgt);
    assign n_w   = CMP_W'(r_count);
    assign pos_n = CNT_W'(pos_w);
    assign tgt_n = CNT_W'(tgt_w);
    assign rot_x = (r_func == FN_ROTL) ? pos_n : r_count - pos_n;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_flags.func      = r_func;
        o_flags.lo_lt_hi  = r_lo < r_hi;
        o_flags.ins_full  = r_count == CNT_W'(CAPACITY);
        o_flags.rem_bad   = pos_w >= n_w;
        o_flags.mov_bad   = (pos_w >= n_w) || (tgt_w >= n_w);
        o_flags.mov_eq    = pos_w == tgt_w;
        o_flags.mov_up    = pos_w > tgt_w;
        o_flags.rot_zero  = pos_w == '0;
        o_flags.rot_bad   = pos_w >= n_w;
        o_flags.n_lt2     = r_count < CNT_W'(2);
        o_flags.empty     = r_count == '0;
        o_flags.dump_last = r_lo == r_count - CNT_W'(1);
        o_flags.out_free  = out_free;
    end

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        unique case (i_cmd.setup)
            SET_NONE: begin
                if (i_cmd.lo_inc) n_lo = r_lo + CNT_W'(1);
                if (i_cmd.hi_dec) n_hi = r_hi - CNT_W'(1);
            end
            SET_INS: begin
                n_lo = (pos_w > n_w) ? r_count : pos_n;
                n_hi = r_count;
            end
            SET_REM: begin
                n_lo = pos_n;
                n_hi = r_count - CNT_W'(1);
            end
            SET_MVDN: begin
                n_lo = pos_n;
                n_hi = tgt_n;
            end
            SET_MVUP: begin
                n_lo = tgt_n;
                n_hi = pos_n;
            end
            SET_REV_ALL: begin
                n_lo = '0;
                n_hi = r_count - CNT_W'(1);
            end
            SET_ROT_A: begin
                n_lo = '0;
                n_hi = rot_x - CNT_W'(1);
            end
            SET_ROT_B: begin
                n_lo = rot_x;
                n_hi = r_count - CNT_W'(1);
            end
            SET_DUMP: begin
                n_lo = '0;
            end
            default: begin
                n_lo = r_lo;
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.rd)
            RD_LO:   raddr_c = r_lo;
            RD_HI:   raddr_c = r_hi;
            RD_LO1:  raddr_c = r_lo + CNT_W'(1);
            RD_HI1:  raddr_c = r_hi - CNT_W'(1);
            RD_POS:  raddr_c = pos_n;
            default: raddr_c = r_lo;
        endcase
    end

    always_comb begin
        we      = 1'b1;
        waddr_c = r_lo;
        wdata   = r_rdata;
        unique case (i_cmd.wr)
            WR_NONE:     we = 1'b0;
            WR_LO_RD:    waddr_c = r_lo;
            WR_HI_RD:    waddr_c = r_hi;
            WR_HI_HOLD: begin
                waddr_c = r_hi;
                wdata   = r_hold;
            end
            WR_TGT_HOLD: begin
                waddr_c = tgt_n;
                wdata   = r_hold;
            end
            WR_LO_VAL:   wdata = r_val;
            default:     we = 1'b0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.cnt)
            CNT_INC: n_count = r_count + CNT_W'(1);
            CNT_DEC: n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr_c[IDX_W-1:0]] <= wdata;
        r_rdata <= mem[raddr_c[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (i_cmd.hold_ld) r_hold <= r_rdata;
        if (i_cmd.load_op) begin
            r_func <= i_func;
            r_val  <= i_value;
            r_pos  <= i_position;
            r_tgt  <= i_target_position;
        end
        if (i_cmd.out == OUT_STATUS) begin
            r_out_value  <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= i_cmd.code;
        end else if (i_cmd.out == OUT_DUMP) begin
            r_out_value  <= $signed(r_rdata);
            r_out_last   <= o_flags.dump_last;
            r_out_status <= ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.out != OUT_NONE) r_out_valid <= 1'b1;
            else if (i_out_ready)      r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_res = r_out_value;
    assign o_last      = r_out_last;
    assign o_status    = r_out_status;

endmodule

`default_nettype wire

### src/ple_controller.sv
`default_nettype none

module ple_controller (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  ple_pkg::t_flags  i_flags,
    output logic             o_in_ready,
    output ple_pkg::t_cmd    o_cmd
);
    import ple_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;
    t_status    r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_code  <= n_code;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_code  = r_code;
        o_cmd   = '{load_op: 1'b0, setup: SET_NONE, lo_inc: 1'b0, hi_dec: 1'b0,
                    rd: RD_LO, wr: WR_NONE, hold_ld: 1'b0, cnt: CNT_HOLD,
                    out: OUT_NONE, code: ST_OK};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_op = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_REPLY;
                n_code  = ST_REJECT;
                unique case (i_flags.func)
                    FN_INSERT: begin
                        if (!i_flags.ins_full) begin
                            o_cmd.setup = SET_INS;
                            n_state = S_SU_RD;
                        end
                    end
                    FN_REMOVE: begin
                        if (!i_flags.rem_bad) begin
                            o_cmd.setup = SET_REM;
                            n_state = S_SD_RD;
                        end
                    end
                    FN_DUMP: begin
                        if (i_flags.empty) begin
                            n_code = ST_EMPTY;
                        end else begin
                            o_cmd.setup = SET_DUMP;
                            n_state = S_DP_RD;
                        end
                    end
                    FN_MOVE: begin
                        if (!i_flags.mov_bad) begin
                            if (i_flags.mov_eq) n_code = ST_OK;
                            else n_state = S_MV_RD;
                        end
                    end
                    FN_REVERSE: begin
                        if (i_flags.n_lt2) begin
                            n_code = ST_OK;
                        end else begin
                            o_cmd.setup = SET_REV_ALL;
                            n_step  = 2'd2;
                            n_state = S_RV_RD0;
                        end
                    end
                    FN_ROTL, FN_ROTR: begin
                        if (i_flags.rot_zero) begin
                            n_code = ST_OK;
                        end else if (!i_flags.rot_bad) begin
                            o_cmd.setup = SET_ROT_A;
                            n_step  = 2'd0;
                            n_state = S_RV_RD0;
                        end
                    end
                    default: n_code = ST_REJECT;
                endcase
            end
            S_SU_RD: begin
                o_cmd.rd = RD_HI1;
                n_state = i_flags.lo_lt_hi ? S_SU_WR : S_DONE;
            end
            S_SU_WR: begin
                o_cmd.wr     = WR_HI_RD;
                o_cmd.hi_dec = 1'b1;
                n_state = S_SU_RD;
            end
            S_SD_RD: begin
                o_cmd.rd = RD_LO1;
                n_state = i_flags.lo_lt_hi ? S_SD_WR : S_DONE;
            end
            S_SD_WR: begin
                o_cmd.wr     = WR_LO_RD;
                o_cmd.lo_inc = 1'b1;
                n_state = S_SD_RD;
            end
            S_MV_RD: begin
                o_cmd.rd = RD_POS;
                n_state = S_MV_HOLD;
            end
            S_MV_HOLD: begin
                o_cmd.hold_ld = 1'b1;
                if (i_flags.mov_up) begin
                    o_cmd.setup = SET_MVUP;
                    n_state = S_SU_RD;
                end else begin
                    o_cmd.setup = SET_MVDN;
                    n_state = S_SD_RD;
                end
            end
            S_RV_RD0: begin
                o_cmd.rd = RD_LO;
                if (i_flags.lo_lt_hi) begin
                    n_state = S_RV_RD1;
                end else begin
                    unique case (r_step)
                        2'd0: begin
                            o_cmd.setup = SET_ROT_B;
                            n_step = 2'd1;
                        end
                        2'd1: begin
                            o_cmd.setup = SET_REV_ALL;
                            n_step = 2'd2;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RV_RD1: begin
                o_cmd.hold_ld = 1'b1;
                o_cmd.rd = RD_HI;
                n_state = S_RV_W0;
            end
            S_RV_W0: begin
                o_cmd.wr = WR_LO_RD;
                n_state = S_RV_W1;
            end
            S_RV_W1: begin
                o_cmd.wr     = WR_HI_HOLD;
                o_cmd.lo_inc = 1'b1;
                o_cmd.hi_dec = 1'b1;
                n_state = S_RV_RD0;
            end
            S_DP_RD: begin
                o_cmd.rd = RD_LO;
                n_state = S_DP_EMIT;
            end
            S_DP_EMIT: begin
                o_cmd.rd = RD_LO;
                if (i_flags.out_free) begin
                    o_cmd.out = OUT_DUMP;
                    if (i_flags.dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.lo_inc = 1'b1;
                        n_state = S_DP_RD;
                    end
                end
            end
            S_DONE: begin
                if (i_flags.out_free) begin
                    o_cmd.out  = OUT_STATUS;
                    o_cmd.code = ST_OK;
                    if (i_flags.func == FN_INSERT) begin
                        o_cmd.wr  = WR_LO_VAL;
                        o_cmd.cnt = CNT_INC;
                    end else if (i_flags.func == FN_REMOVE) begin
                        o_cmd.cnt = CNT_DEC;
                    end else if (i_flags.func == FN_MOVE) begin
                        o_cmd.wr = WR_TGT_HOLD;
                    end
                    n_state = S_IDLE;
                end
            end
            S_REPLY: begin
                if (i_flags.out_free) begin
                    o_cmd.out  = OUT_STATUS;
                    o_cmd.code = r_code;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire
